// ----- hw/rtl/gmpw_pkg.sv -----
// Package for the grid maximum-path block: widths, score types, config codes,
// saturating add and max helpers. No dependencies.
package gmpw_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned MaxWaivers = 2;
  localparam int unsigned NumScores  = MaxWaivers + 1;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned ColsCfgW   = 11;
  localparam int unsigned WaivW      = 2;
  localparam int unsigned ScoreIdxW  = $clog2(NumScores);
  localparam int unsigned ValueW     = 16;
  localparam int unsigned ScoreW     = 32;
  localparam int unsigned CfgIdxW    = 1;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef score_t [NumScores-1:0] scores_t;
  typedef logic signed [ValueW-1:0] value_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridColumns    = 1'b0,
    CfgWaiversAllowed = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    value_t          value;
    logic            last;
    logic            has_left;
    logic            has_above;
    logic [ColW-1:0] col;
  } cell_ctx_t;

  function automatic score_t sat_add(score_t a, value_t v);
    logic [ScoreW:0] s;
    s = {a[ScoreW-1], a} + {{(ScoreW + 1 - ValueW){v[ValueW-1]}}, v};
    if (s[ScoreW] != s[ScoreW-1]) begin
      return s[ScoreW] ? {1'b1, {(ScoreW - 1){1'b0}}} : {1'b0, {(ScoreW - 1){1'b1}}};
    end
    return s[ScoreW-1:0];
  endfunction

  function automatic score_t score_max(score_t a, score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- hw/rtl/grid_max_path_with_waivers.sv -----
// Grid maximum-path top level: input stage, row buffer, cell unit, result
// register and configuration registers. Depends on gmpw_pkg, gmpw_row_buf,
// gmpw_cell_unit.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  cell_value_i, last_cell_i
//   out      output     out_valid_o/out_ready_i best_total_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One cell per cycle; a last cell's result goes through the input stage and
// then the result register. The row buffer read is issued when the cell is
// accepted and used from the input stage, with a same-column write forwarded.
// Reset: grid_columns 1, waivers_allowed 2, new grid. The row buffer is not
// cleared. A last cell waits in the input stage while the result register is
// full; other cells never stall. cfg_ready_o is always high.
module grid_max_path_with_waivers (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gmpw_pkg::value_t                    cell_value_i,
  input  logic                                last_cell_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gmpw_pkg::score_t                    best_total_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gmpw_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gmpw_pkg::ColsCfgW-1:0]       cfg_data_i
);
  import gmpw_pkg::*;

  logic [ColsCfgW-1:0] grid_cols_q;
  logic [WaivW-1:0]    waivers_q;
  logic [ColsCfgW-1:0] cols_eff;
  logic [ColsCfgW-1:0] col_inc;
  logic [ColW-1:0]     col_q, col_d;
  logic                first_row_q, first_row_d;
  logic                s1_valid_q, s1_valid_d;
  cell_ctx_t           s1_q;
  scores_t             left_q, left_d;
  scores_t             above;
  scores_t             score;
  logic                out_valid_q, out_valid_d;
  score_t              best_q;
  logic                out_free, s1_adv, in_acc;
  logic [ScoreIdxW-1:0] w_sel;
  cfg_idx_e            cfg_idx;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= ColsCfgW'(1);
      waivers_q   <= WaivW'(MaxWaivers);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CfgGridColumns:    grid_cols_q <= cfg_data_i;
        CfgWaiversAllowed: waivers_q   <= cfg_data_i[WaivW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_cols_q == '0) begin
      cols_eff = ColsCfgW'(1);
    end else if (grid_cols_q > ColsCfgW'(MaxColumns)) begin
      cols_eff = ColsCfgW'(MaxColumns);
    end else begin
      cols_eff = grid_cols_q;
    end
  end

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_q.last || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // sweep position
  assign col_inc = {1'b0, col_q} + ColsCfgW'(1);

  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    if (in_acc) begin
      if (last_cell_i) begin
        col_d       = '0;
        first_row_d = 1'b1;
      end else if (col_inc >= cols_eff) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.value     <= cell_value_i;
      s1_q.last      <= last_cell_i;
      s1_q.has_left  <= (col_q != '0);
      s1_q.has_above <= !first_row_q;
      s1_q.col       <= col_q;
    end
  end

  gmpw_row_buf u_row_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s1_adv && !s1_q.last),
    .wr_addr_i (s1_q.col),
    .wr_data_i (score),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (above)
  );

  gmpw_cell_unit u_cell_unit (
    .ctx_i   (s1_q),
    .left_i  (left_q),
    .above_i (above),
    .score_o (score)
  );

  always_comb begin
    left_d = left_q;
    if (s1_adv) begin
      left_d = s1_q.last ? '0 : score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  // result
  assign w_sel = (waivers_q > WaivW'(MaxWaivers)) ? ScoreIdxW'(MaxWaivers)
                                                  : ScoreIdxW'(waivers_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_q.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last) begin
      best_q <= score[w_sel];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_total_o = best_q;

`ifndef SYNTH
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.last))
    else $error("result without a last cell");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.last && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while last cell is stalled");

  a_grid_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_cell_i) |=> (col_q == '0 && first_row_q))
    else $error("sweep not restarted after last cell");

  a_first_cell_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && col_q == '0) |=> !s1_q.has_left)
    else $error("left neighbor used in column zero");
`endif

endmodule

// ----- hw/rtl/gmpw_row_buf.sv -----
// Row buffer: scores of the row above, one entry per column, registered read
// with forwarding of a same-cycle write. Depends on gmpw_pkg.
module gmpw_row_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [gmpw_pkg::ColW-1:0] wr_addr_i,
  input  gmpw_pkg::scores_t        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [gmpw_pkg::ColW-1:0] rd_addr_i,
  output gmpw_pkg::scores_t        rd_data_o
);
  import gmpw_pkg::*;

  scores_t mem [MaxColumns];
  scores_t rdata_q;
  scores_t fwd_data_q;
  logic    fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ----- hw/rtl/gmpw_cell_unit.sv -----
// Per-cell score update: best score for each waiver count from the left and
// above neighbors. Combinational. Depends on gmpw_pkg.
module gmpw_cell_unit (
  input  gmpw_pkg::cell_ctx_t ctx_i,
  input  gmpw_pkg::scores_t   left_i,
  input  gmpw_pkg::scores_t   above_i,
  output gmpw_pkg::scores_t   score_o
);
  import gmpw_pkg::*;

  scores_t add_left;
  scores_t add_above;
  scores_t best;
  logic    neg;

  assign neg = ctx_i.value[ValueW-1];

  always_comb begin
    for (int k = 0; k < NumScores; k++) begin
      add_left[k]  = sat_add(left_i[k], ctx_i.value);
      add_above[k] = sat_add(above_i[k], ctx_i.value);
      if (!ctx_i.has_left && !ctx_i.has_above) begin
        best[k] = {{(ScoreW - ValueW){ctx_i.value[ValueW-1]}}, ctx_i.value};
      end else if (ctx_i.has_left && ctx_i.has_above) begin
        best[k] = score_max(add_left[k], add_above[k]);
      end else if (ctx_i.has_left) begin
        best[k] = add_left[k];
      end else begin
        best[k] = add_above[k];
      end
    end
    for (int k = 1; k < NumScores; k++) begin
      if (neg) begin
        if (!ctx_i.has_left && !ctx_i.has_above) begin
          best[k] = '0;
        end
        if (ctx_i.has_left) begin
          best[k] = score_max(best[k], left_i[k-1]);
        end
        if (ctx_i.has_above) begin
          best[k] = score_max(best[k], above_i[k-1]);
        end
      end
    end
  end

  assign score_o = best;

endmodule

// ----- verif/grid_max_path_with_waivers_tb.sv -----
// Testbench for grid_max_path_with_waivers: streams grids through the cell port,
// predicts each best path total in a scoreboard class and checks the results.
// Depends on gmpw_pkg and the grid_max_path_with_waivers RTL.
module grid_max_path_with_waivers_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gmpw_pkg::*;

  class best_path_scoreboard;
    score_t              row_above[MaxColumns][NumScores];
    score_t              left[NumScores];
    int unsigned         col_pos;
    bit                  first_row;
    logic [ColsCfgW-1:0] cols_reg;
    logic [WaivW-1:0]    waivers_reg;
    score_t              totals_due[$];
    int                  errors;

    function new();
      foreach (row_above[i, k]) row_above[i][k] = '0;
      foreach (left[k]) left[k] = '0;
      col_pos     = 0;
      first_row   = 1'b1;
      cols_reg    = 1;
      waivers_reg = 2;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ColsCfgW-1:0] data);
      case (cfg_idx_e'(idx))
        CfgGridColumns:    cols_reg = data;
        CfgWaiversAllowed: waivers_reg = data[WaivW-1:0];
        default: ;
      endcase
    endfunction

    function score_t sat_sum(score_t a, value_t v);
      longint s;
      s = longint'(a) + longint'(v);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return score_t'(s);
    endfunction

    function void offer(input score_t p[NumScores], input value_t v, input int k,
                        inout bit have, inout score_t best);
      score_t c;
      c = sat_sum(p[k], v);
      if (!have || c > best) begin
        best = c;
        have = 1'b1;
      end
      if (v < 0 && k > 0 && p[k-1] > best) best = p[k-1];
    endfunction

    function void take_cell(value_t v, logic last);
      int unsigned ncols;
      int unsigned col;
      int unsigned w;
      score_t      sc[NumScores];
      score_t      best;
      bit          have;
      ncols = (cols_reg == 0) ? 1 : ((cols_reg > MaxColumns) ? MaxColumns : cols_reg);
      col   = (col_pos >= MaxColumns) ? MaxColumns - 1 : col_pos;
      for (int k = 0; k < NumScores; k++) begin
        have = 1'b0;
        best = '0;
        if (col == 0 && first_row) begin
          best = v;
          if (v < 0 && k > 0) best = '0;
        end else begin
          if (col > 0) offer(left, v, k, have, best);
          if (!first_row) offer(row_above[col], v, k, have, best);
        end
        sc[k] = best;
      end
      if (last) begin
        w = (waivers_reg > MaxWaivers) ? MaxWaivers : waivers_reg;
        totals_due.push_back(sc[w]);
        foreach (left[k]) left[k] = '0;
        col_pos   = 0;
        first_row = 1'b1;
        return;
      end
      row_above[col] = sc;
      left = sc;
      col++;
      if (col >= ncols) begin
        col = 0;
        first_row = 1'b0;
      end
      col_pos = col;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_total(score_t got);
      score_t want;
      if (totals_due.size() == 0) begin
        report($sformatf("unexpected best_total %0d", got));
        return;
      end
      want = totals_due.pop_front();
      if (got !== want) report($sformatf("best_total %0d, predicted %0d", got, want));
    endtask

    task flush();
      while (totals_due.size() > 0) begin
        report($sformatf("best_total %0d never arrived", totals_due.pop_front()));
      end
    endtask

    function int pending();
      return totals_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  value_t              cell_value_i = '0;
  logic                last_cell_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  score_t              best_total_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [ColsCfgW-1:0] cfg_data_i   = '0;

  best_path_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_cyc  = 0;
  int unsigned eff_cols   = 1;
  int unsigned rand_items = 0;

  grid_max_path_with_waivers uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cell_value_i(cell_value_i),
    .last_cell_i (last_cell_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_total_o(best_total_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (out_valid_o && out_ready_i) sb.check_total(best_total_o);
      if (in_valid_i && in_ready_o) sb.take_cell(cell_value_i, last_cell_i);
    end
  end

  // result-side backpressure, changing pattern every stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 200);
      end
      stall_left--;
      stall_cyc++;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= (stall_cyc[1:0] != 2'b00);
      endcase
    end
  end

  task automatic send_cell(value_t v, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    cell_value_i <= v;
    last_cell_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [ColsCfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(logic [ColsCfgW-1:0] cols, logic [WaivW-1:0] waivers);
    logic [ColsCfgW-1:0] wdata;
    wdata = {(ColsCfgW - WaivW)'($urandom_range(0, 511)), waivers};
    wait_idle();
    if ($urandom_range(0, 1)) begin
      cfg_write(CfgGridColumns, cols);
      cfg_write(CfgWaiversAllowed, wdata);
    end else begin
      cfg_write(CfgWaiversAllowed, wdata);
      cfg_write(CfgGridColumns, cols);
    end
    eff_cols = (cols == 0) ? 1 : ((cols > MaxColumns) ? MaxColumns : cols);
  endtask

  task automatic send_cells(value_t vals[$]);
    foreach (vals[i]) send_cell(vals[i], i == vals.size() - 1);
  endtask

  function automatic value_t pick_value(int unsigned mode);
    case (mode)
      0: return value_t'($urandom_range(0, 65535));
      1: return value_t'(int'($urandom_range(0, 40)) - 20);
      2: begin
        case ($urandom_range(0, 4))
          0: return value_t'(-32768);
          1: return value_t'(32767);
          2: return value_t'(-1);
          3: return value_t'(0);
          default: return value_t'(1);
        endcase
      end
      default: return ($urandom_range(0, 3) == 0) ? value_t'($urandom_range(0, 32767))
                                                  : value_t'(-int'($urandom_range(1, 32768)));
    endcase
  endfunction

  task automatic random_grid();
    int unsigned rows;
    int unsigned n;
    int unsigned mode;
    rows = (eff_cols >= 64) ? $urandom_range(1, 2) : $urandom_range(1, 8);
    n    = rows * eff_cols;
    if ($urandom_range(0, 5) == 0 || eff_cols >= 64 && $urandom_range(0, 1)) begin
      n = $urandom_range(1, n);
    end
    // keep the total item count near its target
    if (rand_items + n > 1600) n = 1600 - rand_items;
    mode = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++) send_cell(pick_value(mode), i == n - 1);
    rand_items += n;
  endtask

  initial begin
    int unsigned r;
    int unsigned ngrids;
    logic [ColsCfgW-1:0] cols;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one column, two waivers; single-cell grids
    send_cells('{value_t'(-32768)});
    send_cells('{value_t'(32767)});
    send_cells('{value_t'(0)});
    set_grid(3, 0);
    send_cells('{value_t'(-32768), value_t'(32767), value_t'(-1),
                 value_t'(1), value_t'(-32768), value_t'(32767)});
    // zero columns acts as one, waiver count three acts as two
    set_grid(0, 3);
    send_cells('{value_t'(-5), value_t'(-7), value_t'(-32768)});
    // column count above the row buffer, last cell early on the first row
    set_grid(2047, 1);
    send_cells('{value_t'(100), value_t'(-200), value_t'(5)});
    // last cell early on the second row
    set_grid(4, 2);
    send_cells('{value_t'(3), value_t'(-9), value_t'(-32768), value_t'(7),
                 value_t'(-4), value_t'(12)});

    while (rand_items < 1500) begin
      r = $urandom_range(0, 39);
      case (r)
        0: cols = 0;
        1: cols = 2047;
        2: cols = 1024;
        3: cols = ColsCfgW'($urandom_range(1025, 2046));
        4, 5, 6, 7, 8, 9, 10, 11, 12, 13: cols = ColsCfgW'($urandom_range(1, 3));
        14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25: cols = ColsCfgW'($urandom_range(4, 12));
        default: cols = ColsCfgW'($urandom_range(13, 64));
      endcase
      set_grid(cols, WaivW'($urandom_range(0, 3)));
      ngrids = (eff_cols >= 64) ? 1 : $urandom_range(1, 4);
      repeat (ngrids) random_grid();
    end

    wait_idle();
    sb.flush();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
